### rtl/cbw_pkg.sv
// Shared constants, types and helpers for the buffered character LCD writer.
package cbw_pkg;

	localparam int SLOTS   = 4;
	localparam int MAX_LEN = 16;
	localparam int COLUMNS = 16;
	localparam int ROWS    = 2;

	localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LEN_W     = $clog2(MAX_LEN + 1);
	localparam int TXT_DEPTH = SLOTS * MAX_LEN;
	localparam int TXT_AW    = (TXT_DEPTH > 1) ? $clog2(TXT_DEPTH) : 1;

	localparam logic [1:0] FN_TICK  = 2'd0;
	localparam logic [1:0] FN_CHAR  = 2'd1;
	localparam logic [1:0] FN_CLEAR = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_POS = 2'd1;
	localparam logic [1:0] ST_NO_SLOT = 2'd2;
	localparam logic [1:0] ST_TOO_LONG = 2'd3;

	localparam logic [7:0] CMD_FUNC_SET = 8'h38;
	localparam logic [7:0] CMD_DISP_ON  = 8'h0C;
	localparam logic [7:0] CMD_CLEAR    = 8'h01;
	localparam logic [7:0] CMD_ENTRY    = 8'h06;
	localparam logic [7:0] CMD_HOME     = 8'h02;
	localparam logic [7:0] CMD_DDRAM    = 8'h80;
	localparam logic [7:0] ROW1_OFFSET  = 8'h40;

	typedef enum logic [2:0] {
		IS_PINS, IS_START, IS_FUNC, IS_DISP, IS_CLR, IS_ENTRY, IS_HOME, IS_DONE
	} init_t;

	typedef enum logic [1:0] {
		WS_START, WS_ADDR, WS_DATA, WS_FREE
	} wstep_t;

	function automatic logic [7:0] init_cmd(init_t step);
		logic [7:0] c;
		case (step)
			IS_FUNC:  c = CMD_FUNC_SET;
			IS_DISP:  c = CMD_DISP_ON;
			IS_CLR:   c = CMD_CLEAR;
			IS_ENTRY: c = CMD_ENTRY;
			IS_HOME:  c = CMD_HOME;
			default:  c = CMD_HOME;
		endcase
		return c;
	endfunction

endpackage

### rtl/cbw_if.sv
// Valid/ready channel interfaces for request and result beats.
interface cbw_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] char_code;
	logic       row;
	logic [3:0] col;
	logic       last_char;

	modport source (output valid, func, char_code, row, col, last_char, input ready);
	modport sink   (input valid, func, char_code, row, col, last_char, output ready);
endinterface

interface cbw_rsp_if;
	logic       valid;
	logic       ready;
	logic       rs_pin;
	logic       enable_pin;
	logic [7:0] data_bus;
	logic       busy_res;
	logic       init_done;
	logic [1:0] status;

	modport source (output valid, rs_pin, enable_pin, data_bus, busy_res, init_done, status,
		input ready);
	modport sink   (input valid, rs_pin, enable_pin, data_bus, busy_res, init_done, status,
		output ready);
endinterface

### rtl/cbw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cbw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### rtl/char_lcd_buffered_writer.sv
// Top level of the buffered character LCD writer: init sequencer, string slots, output.
// A request beat is registered in the input stage, processed in one pass, and its result
// beat is held in the result register until rsp takes it; one beat per cycle sustained
// when rsp is ready. Rate is set by the single-pass state update between the input and
// result registers.
// Reset (arst_n low, asynchronous): init restarts at pin setup, strobe low, all slots
// empty, no clear pending, latched RS and data bus zero. The text store is not cleared.
module char_lcd_buffered_writer
	import cbw_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	cbw_req_if.sink   req,
	cbw_rsp_if.source rsp
);

	// Input register stage.
	logic             valid_s1;
	logic [1:0]       func_s1;
	logic [7:0]       char_s1;
	logic             row_s1;
	logic [3:0]       col_s1;
	logic             last_s1;
	logic             advance;

	// Controller state.
	init_t            init_step_q, n_init_step;
	logic             init_flag_q, n_init_flag;
	wstep_t           wstep_q, n_wstep;
	logic             strobe_q, n_strobe;
	logic             rs_q, n_rs;
	logic [7:0]       bus_q, n_bus;
	logic             clear_pending_q, n_clear_pending;
	logic             clear_active_q, n_clear_active;
	logic             req_active_q, n_req_active;
	logic [SLOT_W-1:0] serving_q, n_serving;
	logic [SLOT_W-1:0] filling_q, n_filling;
	logic             fill_valid_q, n_fill_valid;
	logic [LEN_W-1:0] fill_len_q, n_fill_len;

	logic             slot_full_q   [SLOTS];
	logic             n_slot_full   [SLOTS];
	logic [LEN_W-1:0] slot_cursor_q [SLOTS];
	logic [LEN_W-1:0] n_slot_cursor [SLOTS];
	logic             slot_row_q    [SLOTS];
	logic             n_slot_row    [SLOTS];
	logic [3:0]       slot_col_q    [SLOTS];
	logic [3:0]       n_slot_col    [SLOTS];
	logic [LEN_W-1:0] slot_len_q    [SLOTS];
	logic [LEN_W-1:0] n_slot_len    [SLOTS];

	logic [1:0]       status;

	// Text store and its read-after-write bypass.
	logic              txt_we;
	logic [TXT_AW-1:0] txt_waddr;
	logic [TXT_AW-1:0] txt_raddr;
	logic [7:0]        txt_rdata;
	logic              byp_q;
	logic [7:0]        byp_data_q;
	logic [7:0]        txt_byte;

	// Result register.
	logic             out_valid_q;
	logic             out_rs_q;
	logic             out_en_q;
	logic [7:0]       out_bus_q;
	logic             out_busy_q;
	logic             out_init_q;
	logic [1:0]       out_status_q;

	// Process the held beat whenever the result register is free or draining.
	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			func_s1 <= req.func;
			char_s1 <= req.char_code;
			row_s1  <= req.row;
			col_s1  <= req.col;
			last_s1 <= req.last_char;
		end
	end

	cbw_ram #(
		.WIDTH (8),
		.DEPTH (TXT_DEPTH)
	) u_text (
		.clk   (clk),
		.we    (txt_we),
		.waddr (txt_waddr),
		.wdata (char_s1),
		.raddr (txt_raddr),
		.rdata (txt_rdata)
	);

	// A character written to the very entry being fetched is forwarded from here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else begin
			byp_q <= txt_we && (txt_waddr == txt_raddr);
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= char_s1;
	end

	assign txt_byte = byp_q ? byp_data_q : txt_rdata;

	// Next-state logic: one tick, character or clear request per pass.
	always_comb begin
		logic [SLOT_W-1:0] s;
		logic [SLOT_W-1:0] free_idx;
		logic              free_found;
		logic [SLOT_W-1:0] next_idx;
		logic              next_found;
		logic [LEN_W-1:0]  cur_len;
		logic [LEN_W-1:0]  new_len;
		logic [7:0]        addr_cmd;

		n_init_step     = init_step_q;
		n_init_flag     = init_flag_q;
		n_wstep         = wstep_q;
		n_strobe        = strobe_q;
		n_rs            = rs_q;
		n_bus           = bus_q;
		n_clear_pending = clear_pending_q;
		n_clear_active  = clear_active_q;
		n_req_active    = req_active_q;
		n_serving       = serving_q;
		n_filling       = filling_q;
		n_fill_valid    = fill_valid_q;
		n_fill_len      = fill_len_q;
		n_slot_full     = slot_full_q;
		n_slot_cursor   = slot_cursor_q;
		n_slot_row      = slot_row_q;
		n_slot_col      = slot_col_q;
		n_slot_len      = slot_len_q;
		status          = ST_OK;
		txt_we          = 1'b0;
		txt_waddr       = '0;

		s        = serving_q;
		addr_cmd = (8'(slot_col_q[s]) + (slot_row_q[s] ? ROW1_OFFSET : 8'h00)) | CMD_DDRAM;

		// Lowest empty slot for a new string.
		free_idx   = '0;
		free_found = 1'b0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!slot_full_q[i]) begin
				free_idx   = SLOT_W'(i);
				free_found = 1'b1;
			end
		end

		// Lowest filled slot other than the one being freed.
		next_idx   = '0;
		next_found = 1'b0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (slot_full_q[i] && (SLOT_W'(i) != s)) begin
				next_idx   = SLOT_W'(i);
				next_found = 1'b1;
			end
		end

		cur_len = fill_valid_q ? fill_len_q : '0;
		new_len = cur_len;

		if (advance) begin
			case (func_s1)
				FN_TICK: begin
					if (!init_flag_q) begin
						case (init_step_q)
							IS_PINS: n_init_step = IS_START;
							IS_START: begin
								n_strobe    = 1'b0;
								n_init_step = IS_FUNC;
							end
							IS_FUNC, IS_DISP, IS_CLR, IS_ENTRY, IS_HOME: begin
								if (!strobe_q) begin
									n_rs     = 1'b0;
									n_bus    = init_cmd(init_step_q);
									n_strobe = 1'b1;
								end else begin
									n_strobe    = 1'b0;
									n_init_step = init_t'(init_step_q + 3'd1);
								end
							end
							default: n_init_flag = 1'b1;
						endcase
					end else if (strobe_q && clear_active_q) begin
						// Finish the clear strobe.
						n_strobe        = 1'b0;
						n_clear_active  = 1'b0;
						n_clear_pending = 1'b0;
					end else if (!strobe_q && clear_pending_q &&
						(!req_active_q || wstep_q == WS_START)) begin
						n_rs           = 1'b0;
						n_bus          = CMD_CLEAR;
						n_strobe       = 1'b1;
						n_clear_active = 1'b1;
					end else if (req_active_q) begin
						case (wstep_q)
							WS_START: begin
								n_strobe = 1'b0;
								n_wstep  = WS_ADDR;
							end
							WS_ADDR: begin
								if (!strobe_q) begin
									n_rs     = 1'b0;
									n_bus    = addr_cmd;
									n_strobe = 1'b1;
								end else begin
									n_strobe = 1'b0;
									n_wstep  = WS_DATA;
								end
							end
							WS_DATA: begin
								if (slot_cursor_q[s] < slot_len_q[s]) begin
									if (!strobe_q) begin
										n_rs     = 1'b1;
										n_bus    = txt_byte;
										n_strobe = 1'b1;
									end else begin
										n_strobe         = 1'b0;
										n_slot_cursor[s] = slot_cursor_q[s] + LEN_W'(1);
									end
								end else begin
									n_wstep = WS_FREE;
								end
							end
							default: begin
								// Free the slot and move on to the lowest waiting one.
								n_slot_full[s] = 1'b0;
								n_wstep        = WS_START;
								if (next_found) begin
									n_serving = next_idx;
								end else begin
									n_req_active = 1'b0;
									n_serving    = '0;
								end
							end
						endcase
					end else begin
						n_strobe = 1'b0;
					end
				end
				FN_CHAR: begin
					if (!fill_valid_q && (int'(row_s1) >= ROWS || int'(col_s1) >= COLUMNS)) begin
						status = ST_BAD_POS;
					end else if (!fill_valid_q && !free_found) begin
						status = ST_NO_SLOT;
					end else begin
						if (!fill_valid_q) begin
							n_filling             = free_idx;
							n_slot_row[free_idx]  = row_s1;
							n_slot_col[free_idx]  = col_s1;
						end
						if (cur_len < LEN_W'(MAX_LEN)) begin
							txt_we    = 1'b1;
							txt_waddr = TXT_AW'(n_filling) * TXT_AW'(MAX_LEN) + TXT_AW'(cur_len);
							new_len   = cur_len + LEN_W'(1);
						end else begin
							status = ST_TOO_LONG;
						end
						n_fill_len   = new_len;
						n_fill_valid = 1'b1;
						if (last_s1) begin
							// Commit the string and start serving if the writer is idle.
							n_slot_full[n_filling]   = 1'b1;
							n_slot_cursor[n_filling] = '0;
							n_slot_len[n_filling]    = new_len;
							n_fill_valid             = 1'b0;
							if (!req_active_q) begin
								n_req_active = 1'b1;
								n_wstep      = WS_START;
								n_serving    = n_filling;
							end
						end
					end
				end
				FN_CLEAR: n_clear_pending = 1'b1;
				default: ;
			endcase
		end

		// Fetch the character the serving slot will send next.
		txt_raddr = TXT_AW'(n_serving) * TXT_AW'(MAX_LEN) +
			TXT_AW'(n_slot_cursor[n_serving]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_step_q     <= IS_PINS;
			init_flag_q     <= 1'b0;
			wstep_q         <= WS_START;
			strobe_q        <= 1'b0;
			rs_q            <= 1'b0;
			bus_q           <= '0;
			clear_pending_q <= 1'b0;
			clear_active_q  <= 1'b0;
			req_active_q    <= 1'b0;
			serving_q       <= '0;
			filling_q       <= '0;
			fill_valid_q    <= 1'b0;
			fill_len_q      <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				slot_full_q[i]   <= 1'b0;
				slot_cursor_q[i] <= '0;
			end
		end else begin
			init_step_q     <= n_init_step;
			init_flag_q     <= n_init_flag;
			wstep_q         <= n_wstep;
			strobe_q        <= n_strobe;
			rs_q            <= n_rs;
			bus_q           <= n_bus;
			clear_pending_q <= n_clear_pending;
			clear_active_q  <= n_clear_active;
			req_active_q    <= n_req_active;
			serving_q       <= n_serving;
			filling_q       <= n_filling;
			fill_valid_q    <= n_fill_valid;
			fill_len_q      <= n_fill_len;
			slot_full_q     <= n_slot_full;
			slot_cursor_q   <= n_slot_cursor;
		end
	end

	// Slot position and length: written only when a string opens or commits.
	always_ff @(posedge clk) begin
		slot_row_q <= n_slot_row;
		slot_col_q <= n_slot_col;
		slot_len_q <= n_slot_len;
	end

	// Result register: hold the beat until rsp takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_rs_q     <= n_rs;
			out_en_q     <= n_strobe;
			out_bus_q    <= n_bus;
			out_busy_q   <= !n_init_flag || n_req_active || n_clear_pending;
			out_init_q   <= n_init_flag;
			out_status_q <= status;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.rs_pin     = out_rs_q;
	assign rsp.enable_pin = out_en_q;
	assign rsp.data_bus   = out_bus_q;
	assign rsp.busy_res   = out_busy_q;
	assign rsp.init_done  = out_init_q;
	assign rsp.status     = out_status_q;

endmodule

### tb/sv/char_lcd_buffered_writer_chk.sv
// Scoreboard for the buffered LCD writer: mirrors its state and checks every result beat.
`timescale 1ns / 100ps

module char_lcd_buffered_writer_chk
	import cbw_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	cbw_req_if   req,
	cbw_rsp_if   rsp,
	output int   errors,
	output int   outstanding,
	output int   beats_seen,
	output int   strings_done,
	output int   slot_refusals,
	output int   chars_cut
);

	localparam int SHOW_MAX = 40;

	typedef struct packed {
		logic       rs;
		logic       en;
		logic [7:0] bus;
		logic       busy;
		logic       done;
		logic [1:0] st;
	} lcd_pins_t;

	lcd_pins_t pins_due[$];

	// mirrored writer state
	init_t      pu_step;
	wstep_t     wr_step;
	logic       strobe;
	logic       init_ok;
	logic       rs_q;
	logic [7:0] bus_q;
	logic       clear_wait;
	logic       clear_busy;
	logic       strings_queued;
	logic       filling_open;
	int         filling;
	int         serving;
	logic       slot_busy    [SLOTS];
	logic       slot_on_row1 [SLOTS];
	logic [3:0] slot_at_col  [SLOTS];
	int         slot_count   [SLOTS];
	int         slot_next    [SLOTS];
	logic [7:0] slot_chars   [SLOTS][MAX_LEN];

	task automatic report(string what, int got, int want);
		errors++;
		if (errors <= SHOW_MAX)
			$display("%0t: %s: got %0h, want %0h", $time, what, got, want);
	endtask

	function automatic void drive_pins(logic rs, logic [7:0] b);
		rs_q   = rs;
		bus_q  = b;
		strobe = 1'b1;
	endfunction

	function automatic void power_up_tick();
		case (pu_step)
			IS_PINS: pu_step = IS_START;
			IS_START: begin
				strobe  = 1'b0;
				pu_step = IS_FUNC;
			end
			IS_DONE: init_ok = 1'b1;
			default: begin
				if (!strobe) begin
					case (pu_step)
						IS_FUNC:  drive_pins(1'b0, CMD_FUNC_SET);
						IS_DISP:  drive_pins(1'b0, CMD_DISP_ON);
						IS_CLR:   drive_pins(1'b0, CMD_CLEAR);
						IS_ENTRY: drive_pins(1'b0, CMD_ENTRY);
						default:  drive_pins(1'b0, CMD_HOME);
					endcase
				end else begin
					strobe  = 1'b0;
					pu_step = init_t'(pu_step + 3'd1);
				end
			end
		endcase
	endfunction

	function automatic void serve_tick();
		int s;
		int i;
		s = serving;
		case (wr_step)
			WS_START: begin
				strobe  = 1'b0;
				wr_step = WS_ADDR;
			end
			WS_ADDR: begin
				if (!strobe)
					drive_pins(1'b0, CMD_DDRAM | ({4'd0, slot_at_col[s]} +
						(slot_on_row1[s] ? ROW1_OFFSET : 8'h00)));
				else begin
					strobe  = 1'b0;
					wr_step = WS_DATA;
				end
			end
			WS_DATA: begin
				if (slot_next[s] < slot_count[s]) begin
					if (!strobe)
						drive_pins(1'b1, slot_chars[s][slot_next[s]]);
					else begin
						strobe = 1'b0;
						slot_next[s]++;
					end
				end else
					wr_step = WS_FREE;
			end
			default: begin
				slot_busy[s] = 1'b0;
				wr_step      = WS_START;
				i = 0;
				while (i < SLOTS && !slot_busy[i])
					i++;
				if (i == SLOTS) begin
					strings_queued = 1'b0;
					serving        = 0;
				end else
					serving = i;
			end
		endcase
	endfunction

	function automatic void lcd_tick();
		if (!init_ok)
			power_up_tick();
		else if (strobe && clear_busy) begin
			strobe     = 1'b0;
			clear_busy = 1'b0;
			clear_wait = 1'b0;
		end else if (!strobe && clear_wait && (!strings_queued || wr_step == WS_START)) begin
			drive_pins(1'b0, CMD_CLEAR);
			clear_busy = 1'b1;
		end else if (strings_queued)
			serve_tick();
		else
			strobe = 1'b0;
	endfunction

	function automatic logic [1:0] store_char(logic [7:0] c, logic r, logic [3:0] cl, logic last);
		logic [1:0] st;
		int         s;
		int         i;
		st = ST_OK;
		if (!filling_open) begin
			if (int'(r) >= ROWS || int'(cl) >= COLUMNS)
				return ST_BAD_POS;
			i = 0;
			while (i < SLOTS && slot_busy[i])
				i++;
			if (i == SLOTS)
				return ST_NO_SLOT;
			filling_open    = 1'b1;
			filling         = i;
			slot_on_row1[i] = r;
			slot_at_col[i]  = cl;
			slot_count[i]   = 0;
		end
		s = filling;
		if (slot_count[s] < MAX_LEN) begin
			slot_chars[s][slot_count[s]] = c;
			slot_count[s]++;
		end else
			st = ST_TOO_LONG;
		if (last) begin
			slot_busy[s]  = 1'b1;
			slot_next[s]  = 0;
			filling_open  = 1'b0;
			strings_done++;
			if (!strings_queued) begin
				strings_queued = 1'b1;
				wr_step        = WS_START;
				serving        = s;
			end
		end
		return st;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lcd_pins_t  want;
		logic [1:0] st;
		if (!arst_n) begin
			pu_step        = IS_PINS;
			wr_step        = WS_START;
			strobe         = 1'b0;
			init_ok        = 1'b0;
			rs_q           = 1'b0;
			bus_q          = 8'h00;
			clear_wait     = 1'b0;
			clear_busy     = 1'b0;
			strings_queued = 1'b0;
			filling_open   = 1'b0;
			filling        = 0;
			serving        = 0;
			for (int i = 0; i < SLOTS; i++) begin
				slot_busy[i]  = 1'b0;
				slot_count[i] = 0;
				slot_next[i]  = 0;
			end
			pins_due.delete();
			errors        = 0;
			beats_seen    = 0;
			strings_done  = 0;
			slot_refusals = 0;
			chars_cut     = 0;
		end else begin
			// check first: a result never leaves on the edge that takes its request
			if (rsp.valid && rsp.ready) begin
				beats_seen++;
				if (pins_due.size() == 0)
					report("result beat with nothing expected", rsp.data_bus, 0);
				else begin
					want = pins_due.pop_front();
					if (rsp.rs_pin !== want.rs)
						report("rs_pin", rsp.rs_pin, want.rs);
					if (rsp.enable_pin !== want.en)
						report("enable_pin", rsp.enable_pin, want.en);
					if (rsp.data_bus !== want.bus)
						report("data_bus", rsp.data_bus, want.bus);
					if (rsp.busy_res !== want.busy)
						report("busy_res", rsp.busy_res, want.busy);
					if (rsp.init_done !== want.done)
						report("init_done", rsp.init_done, want.done);
					if (rsp.status !== want.st)
						report("status", rsp.status, want.st);
				end
			end
			if (req.valid && req.ready) begin
				st = ST_OK;
				case (req.func)
					FN_TICK:  lcd_tick();
					FN_CHAR:  st = store_char(req.char_code, req.row, req.col, req.last_char);
					FN_CLEAR: clear_wait = 1'b1;
					default: ;
				endcase
				if (st == ST_NO_SLOT)
					slot_refusals++;
				if (st == ST_TOO_LONG)
					chars_cut++;
				want = '{rs_q, strobe, bus_q, !init_ok || strings_queued || clear_wait,
					init_ok, st};
				pins_due.push_back(want);
			end
		end
		outstanding = pins_due.size();
	end

endmodule

### tb/sv/char_lcd_buffered_writer_tb.sv
// Top of the buffered LCD writer testbench: clock, reset, request and result traffic, verdict.
`timescale 1ns / 100ps

module char_lcd_buffered_writer_tb;
	import cbw_pkg::*;

	// func code the block has no use for; it must answer with a plain status beat
	localparam logic [1:0] FN_UNUSED = 2'd3;

	localparam int ITEM_GOAL      = 1950;
	localparam int MAX_GAP        = 12;
	localparam int HOLD_CYCLES    = 300;  // long result-side hold-off
	localparam int HOLD_BURST     = 40;   // request beats offered during a hold-off
	localparam int POWER_UP_TICKS = 13;   // pin setup, start, five commands, done
	localparam int DRAIN_CYCLES   = 20;   // result path is two registers deep

	logic clk;
	logic arst_n;

	cbw_req_if req_ch ();
	cbw_rsp_if rsp_ch ();

	int errors;
	int outstanding;
	int beats_seen;
	int strings_done;
	int slot_refusals;
	int chars_cut;

	int items_sent;
	bit no_idle;       // both sides run back to back while set
	bit hold_off_req;  // ask the result side for one long hold-off

	char_lcd_buffered_writer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	char_lcd_buffered_writer_chk u_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req_ch),
		.rsp           (rsp_ch),
		.errors        (errors),
		.outstanding   (outstanding),
		.beats_seen    (beats_seen),
		.strings_done  (strings_done),
		.slot_refusals (slot_refusals),
		.chars_cut     (chars_cut)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop: the slowest legal run needs well under a tenth of this.
	initial begin
		#4_000_000;
		$display("[char_lcd_buffered_writer] ERROR");
		$finish;
	end

	// Offer one request beat after a random gap and hold it until taken.
	task automatic send_beat(logic [1:0] f, logic [7:0] c, logic r, logic [3:0] cl, logic last);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.func      <= f;
		req_ch.char_code <= c;
		req_ch.row       <= r;
		req_ch.col       <= cl;
		req_ch.last_char <= last;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		items_sent++;
	endtask

	// Ticks ignore the other fields, so fill them with noise.
	task automatic send_tick();
		send_beat(FN_TICK, 8'($urandom), 1'($urandom), 4'($urandom), 1'($urandom));
	endtask

	// Send a whole string; row and column count only on the first character,
	// and a tick now and then lands in the middle of the fill.
	task automatic send_text(int len, logic r, logic [3:0] cl);
		for (int i = 0; i < len; i++) begin
			if (i != 0 && $urandom_range(0, 4) == 0)
				send_tick();
			send_beat(FN_CHAR, 8'($urandom), (i == 0) ? r : 1'($urandom),
				(i == 0) ? cl : 4'($urandom), i == len - 1);
		end
	endtask

	// Result side: draw a stall per beat, or honor a long hold-off when asked.
	initial begin
		int stall;
		rsp_ch.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
				if (stall != 0) begin
					rsp_ch.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid)
				@(posedge clk);
		end
	end

	// Request side and verdict.
	initial begin
		int pick;
		bit mid_hold_done;
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.func      = FN_TICK;
		req_ch.char_code = 8'h00;
		req_ch.row       = 1'b0;
		req_ch.col       = 4'h0;
		req_ch.last_char = 1'b0;
		items_sent       = 0;
		no_idle          = 1'b0;
		hold_off_req     = 1'b0;
		mid_hold_done    = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Before init: buffer a string at the far end of row 1 with the byte extremes,
		// hold a clear, and push an unused func with every field at its top.
		send_beat(FN_CHAR, 8'h00, 1'b1, 4'hF, 1'b0);
		send_beat(FN_CHAR, 8'hFF, 1'b1, 4'hF, 1'b1);
		send_beat(FN_CLEAR, 8'h00, 1'b0, 4'h0, 1'b0);
		send_beat(FN_UNUSED, 8'hFF, 1'b1, 4'hF, 1'b1);

		// Walk the power-up sequence to the end.
		repeat (POWER_UP_TICKS) send_tick();

		// Fill the remaining slots, then knock on a full buffer.
		send_beat(FN_CHAR, 8'h41, 1'b0, 4'h0, 1'b1);
		send_beat(FN_CHAR, 8'h7E, 1'b1, 4'h0, 1'b1);
		send_beat(FN_CHAR, 8'h80, 1'b0, 4'h7, 1'b1);
		send_beat(FN_CHAR, 8'h5A, 1'b0, 4'h3, 1'b1);

		// Stall results for a long stretch while ticks keep coming, so the block
		// backs up and drops ready on the request side.
		hold_off_req = 1'b1;
		no_idle      = 1'b1;
		repeat (HOLD_BURST) send_tick();
		no_idle = 1'b0;

		// Random traffic: mostly tick runs and well-formed strings, some overlong
		// strings, clears, unused funcs and raw noise.
		while (items_sent < ITEM_GOAL) begin
			if ($urandom_range(0, 9) == 0)
				no_idle = !no_idle;
			if (!mid_hold_done && items_sent >= ITEM_GOAL / 2) begin
				mid_hold_done = 1'b1;
				hold_off_req  = 1'b1;
				send_text(MAX_LEN, 1'($urandom), 4'($urandom));
				repeat (HOLD_BURST) send_tick();
			end
			pick = $urandom_range(0, 99);
			if (pick < 50)
				repeat ($urandom_range(1, 60)) send_tick();
			else if (pick < 80)
				send_text($urandom_range(1, 8), 1'($urandom), 4'($urandom));
			else if (pick < 88)
				send_text($urandom_range(MAX_LEN - 2, MAX_LEN + 4), 1'($urandom), 4'($urandom));
			else if (pick < 93)
				send_beat(FN_CLEAR, 8'($urandom), 1'($urandom), 4'($urandom), 1'($urandom));
			else if (pick < 96)
				send_beat(FN_UNUSED, 8'($urandom), 1'($urandom), 4'($urandom), 1'($urandom));
			else
				send_beat(2'($urandom), 8'($urandom), 1'($urandom), 4'($urandom),
					1'($urandom));
		end

		// Drop valid and drain the result path.
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run: %0d request beats, %0d result beats, %0d strings committed",
			items_sent, beats_seen, strings_done);
		$display("run: %0d refused for a full buffer, %0d characters cut for length",
			slot_refusals, chars_cut);
		if (errors == 0)
			$display("[char_lcd_buffered_writer] OK");
		else
			$display("[char_lcd_buffered_writer] ERROR");
		$finish;
	end

endmodule

### files.f
rtl/cbw_pkg.sv
rtl/cbw_if.sv
rtl/cbw_ram.sv
rtl/char_lcd_buffered_writer.sv
tb/sv/char_lcd_buffered_writer_chk.sv
tb/sv/char_lcd_buffered_writer_tb.sv
